[hdl/debounced_press_blink_queue_macros.svh]
// ----------------------------------------------------------------------------
// debounced_press_blink_queue_macros
// Assertion macros for the debounced press blink queue checker.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_PRESS_BLINK_QUEUE_MACROS_SVH
`define DEBOUNCED_PRESS_BLINK_QUEUE_MACROS_SVH

// Clocked check, muted while reset is asserted.
`define DBPB_ASSERT(name, clk, rstn, prop) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
		else $error("dbpb assertion failed");

// Clocked check that also holds through reset.
`define DBPB_ASSERT_ALWAYS(name, clk, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("dbpb assertion failed");

`endif

[hdl/dbpb_pkg.sv]
// ----------------------------------------------------------------------------
// dbpb_pkg
// Shared widths, register indexes and result types of the press blink queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dbpb_pkg;

	localparam int TIMER_W  = 16;
	localparam int COUNT_W  = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W = 8;
	localparam int OUT_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ON       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFF      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPEATS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd4;

	localparam logic [TIMER_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [TIMER_W-1:0] ON_RST       = 16'd500;
	localparam logic [TIMER_W-1:0] OFF_RST      = 16'd500;
	localparam logic [COUNT_W-1:0] REPEATS_RST  = 8'd3;
	localparam logic [COUNT_W-1:0] LIMIT_RST    = 8'd5;

	localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

	// One result word; led_level lands in bit 0.
	typedef struct packed {
		logic               sequence_done;
		logic               press_dropped;
		logic               press_accepted;
		logic [COUNT_W-1:0] pending_presses;
		logic               led_level;
	} result_t;

	typedef struct packed {
		logic take;
		logic done;
		logic led;
	} blink_stat_t;

endpackage : dbpb_pkg

`default_nettype wire

[hdl/dbpb_debounce.sv]
// ----------------------------------------------------------------------------
// dbpb_debounce
// Quiet-timer debouncer; flags a stable rising level once per press.
// ----------------------------------------------------------------------------
`default_nettype none

module dbpb_debounce (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic                        sample,
	input  wire logic [dbpb_pkg::TIMER_W-1:0] debounce_ticks,
	output logic                             press_evt
);
	import dbpb_pkg::*;

	logic               prev_q;
	logic               stable_q;
	logic [TIMER_W-1:0] quiet_q;
	logic [TIMER_W-1:0] quiet_n;
	logic               flip;

	always_comb begin
		if (sample != prev_q) begin
			quiet_n = '0;
		end else if (quiet_q != TIMER_MAX) begin
			quiet_n = quiet_q + TIMER_W'(1);
		end else begin
			quiet_n = quiet_q;
		end
		flip      = (quiet_n >= debounce_ticks) && (sample != stable_q);
		press_evt = step && flip && sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= 1'b0;
			stable_q <= 1'b0;
			quiet_q  <= '0;
		end else if (step) begin
			prev_q  <= sample;
			quiet_q <= quiet_n;
			if (flip) begin
				stable_q <= sample;
			end
		end
	end

endmodule : dbpb_debounce

`default_nettype wire

[hdl/dbpb_blinker.sv]
// ----------------------------------------------------------------------------
// dbpb_blinker
// Counted blink sequencer: on phase, off phase, repeated per taken press.
// ----------------------------------------------------------------------------
`default_nettype none

module dbpb_blinker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic                        pending,
	input  wire logic [dbpb_pkg::TIMER_W-1:0] on_ticks,
	input  wire logic [dbpb_pkg::TIMER_W-1:0] off_ticks,
	input  wire logic [dbpb_pkg::COUNT_W-1:0] blink_repeats,
	output dbpb_pkg::blink_stat_t            stat
);
	import dbpb_pkg::*;

	logic               active_q, phase_hi_q;
	logic [TIMER_W-1:0] timer_q;
	logic [COUNT_W-1:0] remain_q;

	logic               active_n, phase_hi_n;
	logic [TIMER_W-1:0] timer_n, timer_inc;
	logic [COUNT_W-1:0] remain_n;

	always_comb begin
		active_n   = active_q;
		phase_hi_n = phase_hi_q;
		timer_n    = timer_q;
		remain_n   = remain_q;
		stat       = '0;
		timer_inc  = (timer_q != TIMER_MAX) ? timer_q + TIMER_W'(1) : timer_q;

		if (active_q) begin
			timer_n = timer_inc;
			if (phase_hi_q) begin
				if (timer_inc >= on_ticks) begin
					phase_hi_n = 1'b0;
					timer_n    = '0;
				end
			end else if (timer_inc >= off_ticks) begin
				timer_n = '0;
				if (remain_q <= COUNT_W'(1)) begin
					remain_n  = '0;
					active_n  = 1'b0;
					stat.done = 1'b1;
				end else begin
					remain_n   = remain_q - COUNT_W'(1);
					phase_hi_n = 1'b1;
				end
			end
		end

		// Take a pending press as soon as the sequencer is free.
		if (!active_n && pending) begin
			stat.take  = 1'b1;
			active_n   = 1'b1;
			phase_hi_n = 1'b1;
			timer_n    = '0;
			remain_n   = blink_repeats;
		end

		stat.led = active_n && phase_hi_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			phase_hi_q <= 1'b0;
			timer_q    <= '0;
			remain_q   <= '0;
		end else if (step) begin
			active_q   <= active_n;
			phase_hi_q <= phase_hi_n;
			timer_q    <= timer_n;
			remain_q   <= remain_n;
		end
	end

endmodule : dbpb_blinker

`default_nettype wire

[hdl/dbpb_out_buf.sv]
// ----------------------------------------------------------------------------
// dbpb_out_buf
// Result register with a skid entry, so one more input word is taken while stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module dbpb_out_buf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire dbpb_pkg::result_t push_data,
	output logic                   space,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output dbpb_pkg::result_t      out_data
);
	import dbpb_pkg::*;

	logic    main_v_q, skid_v_q;
	result_t main_q, skid_q;
	logic    pop;

	assign pop       = main_v_q && out_ready;
	assign space     = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (skid_v_q) begin
				if (pop) begin
					skid_v_q <= 1'b0;
				end
			end else if (push && main_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end else if (push) begin
				main_v_q <= 1'b1;
			end else if (pop) begin
				main_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push && main_v_q && !pop) begin
			skid_q <= push_data;
		end else if (push) begin
			main_q <= push_data;
		end
	end

endmodule : dbpb_out_buf

`default_nettype wire

[hdl/debounced_press_blink_queue.sv]
// ----------------------------------------------------------------------------
// debounced_press_blink_queue
// Button debouncer feeding a press queue that drives a counted LED blinker.
// ----------------------------------------------------------------------------
// Usage:
//   Each input word on s_tvalid/s_tready/s_tdata is one millisecond tick;
//   s_tdata[0] carries the raw button level. Every accepted word yields
//   exactly one result word on m_tvalid/m_tready/m_tdata with the LED level,
//   the pending press count and the accepted, dropped and done flags.
//   Each accepted word's result is registered into the result register, or
//   into the skid entry while the output is stalled. Throughput is one word
//   per cycle while the skid entry is free; all per-tick work is one pass of
//   small counters and compares into the result register. The result register
//   has a skid entry behind it: while the receiver stalls, one more word is
//   taken, then s_tready drops until m_tready frees the skid entry.
//   Registers are written on the cfg channel (cfg_ready is always high); the
//   user must write them while no tick is in flight, which the block does not enforce. Unknown indexes are ignored.
//   Reset clears the debouncer, the queue and the blinker, empties the
//   result buffer and loads the register defaults (50, 500, 500, 3, 5).
// ----------------------------------------------------------------------------
`default_nettype none

module debounced_press_blink_queue (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// s_tdata: [0] button_level, rest zero
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [dbpb_pkg::IN_DATA_W-1:0]  s_tdata,
	// m_tdata: [0] led_level, [8:1] pending_presses, [9] press_accepted,
	//          [10] press_dropped, [11] sequence_done, rest zero
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [dbpb_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [dbpb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dbpb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dbpb_pkg::*;

	// Configuration registers.
	logic [TIMER_W-1:0] debounce_q, on_q, off_q;
	logic [COUNT_W-1:0] repeats_q, limit_q;

	// Press queue count.
	logic [COUNT_W-1:0] count_q;

	logic               step;
	logic               press_evt;
	logic               accepted, dropped;
	logic [COUNT_W-1:0] count_mid, count_n;
	blink_stat_t        blink;
	result_t            result, out_res;
	logic               space;

	assign cfg_ready = 1'b1;
	assign s_tready  = space;
	assign step      = s_tvalid && space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			on_q       <= ON_RST;
			off_q      <= OFF_RST;
			repeats_q  <= REPEATS_RST;
			limit_q    <= LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEBOUNCE: debounce_q <= cfg_data;
				REG_ON:       on_q       <= cfg_data;
				REG_OFF:      off_q      <= cfg_data;
				REG_REPEATS:  repeats_q  <= cfg_data[COUNT_W-1:0];
				REG_LIMIT:    limit_q    <= cfg_data[COUNT_W-1:0];
				default: ; // drop writes to unknown indexes
			endcase
		end
	end

	dbpb_debounce u_debounce (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.sample         (s_tdata[0]),
		.debounce_ticks (debounce_q),
		.press_evt      (press_evt)
	);

	// Queue first, then let the blinker take from the updated count.
	always_comb begin
		accepted  = press_evt && (count_q < limit_q);
		dropped   = press_evt && !(count_q < limit_q);
		count_mid = count_q + COUNT_W'(accepted);
		count_n   = count_mid - COUNT_W'(blink.take);
	end

	dbpb_blinker u_blinker (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.pending       (count_mid != '0),
		.on_ticks      (on_q),
		.off_ticks     (off_q),
		.blink_repeats (repeats_q),
		.stat          (blink)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (step) begin
			count_q <= count_n;
		end
	end

	always_comb begin
		result.led_level       = blink.led;
		result.pending_presses = count_n;
		result.press_accepted  = accepted;
		result.press_dropped   = dropped;
		result.sequence_done   = blink.done;
	end

	dbpb_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step),
		.push_data (result),
		.space     (space),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {(OUT_DATA_W - $bits(result_t))'(0), out_res};

endmodule : debounced_press_blink_queue

`default_nettype wire

[hdl/dbpb_checker.sv]
// ----------------------------------------------------------------------------
// dbpb_checker
// Port-level checks on the press blink queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "debounced_press_blink_queue_macros.svh"

module dbpb_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tready,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [dbpb_pkg::OUT_DATA_W-1:0] m_tdata
);
	import dbpb_pkg::*;

	// A stalled result holds its value.
	`DBPB_ASSERT(a_hold_on_stall, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

	// Input backpressure only appears with a result waiting on the output.
	`DBPB_ASSERT_ALWAYS(a_ready_low_means_full, clk, !s_tready |-> m_tvalid)

	// One press is either queued or dropped, never both.
	`DBPB_ASSERT(a_accept_drop_excl, clk, arst_n, m_tvalid |-> !(m_tdata[9] && m_tdata[10]))

	// Padding bits of the result word stay zero.
	`DBPB_ASSERT(a_pad_zero, clk, arst_n, m_tvalid |-> m_tdata[15:12] == 4'd0)

endmodule : dbpb_checker

bind debounced_press_blink_queue dbpb_checker u_dbpb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
